### hdl/sstl_pkg.sv
// ----------------------------------------------------------------------------
// sstl_pkg
// Shared widths, command/status structs and elaboration-time helpers for the
// static search tree slot assignment block.
// ----------------------------------------------------------------------------
package sstl_pkg;

  localparam int SLOT_W     = 17;
  localparam int KEY_W      = 32;
  localparam int LVL_W      = 2;
  localparam int MAX_LEVELS = 4;
  localparam int DVS_W      = 19;
  localparam int RCP_W      = 18;
  localparam int SHF_W      = 6;

  typedef struct packed {
    logic init;
    logic len_start;
    logic take_len;
    logic take_round;
    logic run;
  } sstl_cmd_t;

  typedef struct packed {
    logic setup_done;
    logic div_done;
    logic cfg_wr;
  } sstl_sts_t;

  function automatic logic [63:0] level_capacity(input int bucket, input int lvl);
    logic [63:0] c;
    c = 64'(bucket);
    if (lvl >= 1) begin
      c = 64'(bucket + 1) * 64'(bucket);
    end
    for (int i = 2; i <= lvl; i++) begin
      c = c * 64'(bucket);
    end
    return c;
  endfunction

  // Divisor saturates at 2^(DVS_W-1): any larger divisor gives a zero quotient too.
  function automatic logic [DVS_W-1:0] sat_divisor(input logic [63:0] cap);
    logic [63:0] d;
    d = cap + 64'd1;
    if (d >= (64'd1 << (DVS_W - 1))) begin
      d = 64'd1 << (DVS_W - 1);
    end
    return d[DVS_W-1:0];
  endfunction

  // x / d for any x below 2^SLOT_W: (x * rcp_mult(d)) >> rcp_shift(d)
  function automatic logic [SHF_W-1:0] rcp_shift(input logic [DVS_W-1:0] d);
    return SHF_W'(SLOT_W + $clog2(d));
  endfunction

  function automatic logic [RCP_W-1:0] rcp_mult(input logic [DVS_W-1:0] d);
    logic [63:0] p;
    p = 64'd1 << rcp_shift(d);
    return RCP_W'((p + 64'(d) - 64'd1) / 64'(d));
  endfunction

endpackage

### hdl/sstl_div.sv
// ----------------------------------------------------------------------------
// sstl_div
// Constant divisor unit: operands registered, then a reciprocal multiply;
// the quotient is valid in the cycle done is high.
// ----------------------------------------------------------------------------
module sstl_div
  import sstl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SLOT_W-1:0] dividend,
  input  logic [RCP_W-1:0]  mult,
  input  logic [SHF_W-1:0]  shift,
  output logic [SLOT_W-1:0] quotient,
  output logic              done
);

  localparam int PROD_W = SLOT_W + RCP_W;

  logic [SLOT_W-1:0] dvd;
  logic [RCP_W-1:0]  mul;
  logic [SHF_W-1:0]  shf;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_shr;
  logic              busy;

  assign prod_shr = prod >> shf;
  assign quotient = prod_shr[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      mul <= mult;
      shf <= shift;
    end
    if (busy) begin
      prod <= PROD_W'(dvd) * PROD_W'(mul);
    end
  end

endmodule

### hdl/sstl_ctrl.sv
// ----------------------------------------------------------------------------
// sstl_ctrl
// Sequencer: level start setup after reset or a count write, then streaming.
// ----------------------------------------------------------------------------
module sstl_ctrl
  import sstl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sstl_sts_t sts,
  output sstl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_CHECK,
    S_DIV_LEN,
    S_DIV_RND,
    S_RUN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT:    state <= S_CHECK;
        S_CHECK:   state <= sts.setup_done ? S_RUN : S_DIV_LEN;
        S_DIV_LEN: if (sts.div_done) state <= S_DIV_RND;
        S_DIV_RND: if (sts.div_done) state <= S_CHECK;
        S_RUN:     if (sts.cfg_wr) state <= S_INIT;
        default:   state <= S_INIT;
      endcase
    end
  end

  assign cmd.init       = (state == S_INIT);
  assign cmd.len_start  = (state == S_CHECK) && !sts.setup_done;
  assign cmd.take_len   = (state == S_DIV_LEN) && sts.div_done;
  assign cmd.take_round = (state == S_DIV_RND) && sts.div_done;
  assign cmd.run        = (state == S_RUN);

endmodule

### hdl/sstl_datapath.sv
// ----------------------------------------------------------------------------
// sstl_datapath
// Level layout registers, per-level write positions and fill counts, level
// pick for each key, and the result register.
// ----------------------------------------------------------------------------
module sstl_datapath
  import sstl_pkg::*;
#(
  parameter int BUCKET    = 16,
  parameter int LEVELS    = 4,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  sstl_cmd_t         cmd,
  output sstl_sts_t         sts,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SLOT_W-1:0] item_count,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KEY_W-1:0]  key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot_index,
  output logic [KEY_W-1:0]  key_out,
  output logic [LVL_W-1:0]  tree_level,
  output logic              last,
  output logic              overflow
);

  localparam int FILL_W = $clog2(BUCKET + 1);

  localparam logic [63:0] CAP [MAX_LEVELS] = '{
    level_capacity(BUCKET, 0), level_capacity(BUCKET, 1),
    level_capacity(BUCKET, 2), level_capacity(BUCKET, 3)
  };
  localparam logic [DVS_W-1:0] DVS_TAB [MAX_LEVELS] = '{
    sat_divisor(CAP[0]), sat_divisor(CAP[1]),
    sat_divisor(CAP[2]), sat_divisor(CAP[3])
  };
  localparam logic [RCP_W-1:0] MUL_TAB [MAX_LEVELS] = '{
    rcp_mult(DVS_TAB[0]), rcp_mult(DVS_TAB[1]),
    rcp_mult(DVS_TAB[2]), rcp_mult(DVS_TAB[3])
  };
  localparam logic [SHF_W-1:0] SHF_TAB [MAX_LEVELS] = '{
    rcp_shift(DVS_TAB[0]), rcp_shift(DVS_TAB[1]),
    rcp_shift(DVS_TAB[2]), rcp_shift(DVS_TAB[3])
  };
  localparam logic [RCP_W-1:0] BKT_MUL = rcp_mult(DVS_W'(BUCKET));
  localparam logic [SHF_W-1:0] BKT_SHF = rcp_shift(DVS_W'(BUCKET));
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_WIDTH >= KEY_W) ? {KEY_W{1'b1}} :
                                          KEY_W'((64'd1 << KEY_WIDTH) - 64'd1);

  logic [SLOT_W-1:0] count_cfg;
  logic [LVL_W-1:0]  top_level;
  logic              too_big;
  logic [SLOT_W-1:0] rem;
  logic [LVL_W-1:0]  lvl_idx;
  logic [SLOT_W-1:0] level_start     [MAX_LEVELS];
  logic [SLOT_W-1:0] level_write_pos [MAX_LEVELS];
  logic [FILL_W-1:0] level_fill_count[MAX_LEVELS];
  logic [SLOT_W-1:0] keys_seen;
  logic [LVL_W-1:0]  tail_level;

  logic [LVL_W-1:0]  top_next;
  logic              top_found;
  logic [LVL_W-1:0]  div_k;
  logic              div_start;
  logic [SLOT_W-1:0] div_dividend;
  logic [RCP_W-1:0]  div_mult;
  logic [SHF_W-1:0]  div_shift;
  logic [SLOT_W-1:0] div_q;
  logic              div_done;
  logic [SLOT_W:0]   len;
  logic [SLOT_W-1:0] rem_next;
  logic [SLOT_W-1:0] round_len;

  logic              accept;
  logic              beyond;
  logic [SLOT_W-1:0] idx;
  logic              is_last;
  logic              main_phase;
  logic              m_found, t_found, sel_found;
  logic [LVL_W-1:0]  m_lvl, t_lvl, sel_lvl;
  logic              ovf;
  logic              write_en;
  logic [FILL_W-1:0] fill_inc;

  always_comb begin
    top_next  = '0;
    top_found = 1'b0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (i < LEVELS && 64'(count_cfg) <= CAP[i]) begin
        top_next  = LVL_W'(i);
        top_found = 1'b1;
      end
    end
  end

  assign div_k        = top_level - lvl_idx - 2'd1;
  assign div_start    = cmd.len_start || cmd.take_len;
  assign div_dividend = cmd.take_len ? (div_q + SLOT_W'(BUCKET)) : rem;
  assign div_mult     = cmd.take_len ? BKT_MUL : MUL_TAB[div_k];
  assign div_shift    = cmd.take_len ? BKT_SHF : SHF_TAB[div_k];
  assign len          = {1'b0, div_q} + (SLOT_W + 1)'(1);
  assign rem_next     = (len > {1'b0, rem}) ? '0 : (rem - len[SLOT_W-1:0]);
  assign round_len    = div_q * SLOT_W'(BUCKET);

  sstl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .mult     (div_mult),
    .shift    (div_shift),
    .quotient (div_q),
    .done     (div_done)
  );

  assign cfg_ready      = cmd.run;
  assign sts.cfg_wr     = cfg_valid && cfg_ready;
  assign sts.div_done   = div_done;
  assign sts.setup_done = too_big || (lvl_idx == top_level);

  assign in_stall   = !cmd.run || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign beyond     = (keys_seen >= count_cfg);
  assign idx        = keys_seen + 1'b1;
  assign is_last    = (idx == count_cfg);
  assign main_phase = ({1'b0, idx} + (SLOT_W + 1)'(top_level)) <= {1'b0, count_cfg};

  always_comb begin
    m_found = 1'b0;
    m_lvl   = '0;
    t_found = 1'b0;
    t_lvl   = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (LVL_W'(i) <= top_level && level_fill_count[i] < FILL_W'(BUCKET)) begin
        m_found = 1'b1;
        m_lvl   = LVL_W'(i);
      end
      if (LVL_W'(i) <= tail_level && level_fill_count[i] < FILL_W'(BUCKET)) begin
        t_found = 1'b1;
        t_lvl   = LVL_W'(i);
      end
    end
  end

  assign sel_found = main_phase ? m_found : t_found;
  assign sel_lvl   = main_phase ? m_lvl : t_lvl;
  assign ovf       = beyond || too_big || !sel_found;
  assign write_en  = accept && !ovf;
  assign fill_inc  = level_fill_count[sel_lvl] + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg  <= '0;
      top_level  <= '0;
      too_big    <= 1'b0;
      rem        <= '0;
      lvl_idx    <= '0;
      keys_seen  <= '0;
      tail_level <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        level_start[i]      <= '0;
        level_write_pos[i]  <= '0;
        level_fill_count[i] <= '0;
      end
    end else begin
      if (sts.cfg_wr) begin
        count_cfg <= item_count;
      end
      if (cmd.init) begin
        top_level  <= top_next;
        too_big    <= !top_found;
        rem        <= count_cfg;
        lvl_idx    <= '0;
        keys_seen  <= '0;
        tail_level <= top_next - 2'd1;
        for (int i = 0; i < MAX_LEVELS; i++) begin
          level_start[i]      <= '0;
          level_write_pos[i]  <= '0;
          level_fill_count[i] <= '0;
        end
      end
      if (cmd.take_len) begin
        rem <= rem_next;
      end
      if (cmd.take_round) begin
        level_start[lvl_idx + 2'd1]     <= level_start[lvl_idx] + round_len;
        level_write_pos[lvl_idx + 2'd1] <= level_start[lvl_idx] + round_len;
        lvl_idx                         <= lvl_idx + 2'd1;
      end
      if (accept && !beyond) begin
        keys_seen <= idx;
      end
      if (write_en) begin
        if (main_phase && fill_inc != FILL_W'(BUCKET)) begin
          for (int i = 0; i < MAX_LEVELS; i++) begin
            if (LVL_W'(i) > sel_lvl) begin
              level_fill_count[i] <= '0;
            end
          end
        end
        level_write_pos[sel_lvl]  <= level_write_pos[sel_lvl] + 1'b1;
        level_fill_count[sel_lvl] <= fill_inc;
        if (!main_phase) begin
          if (sel_lvl == tail_level && sel_lvl != '0) begin
            tail_level <= sel_lvl - 2'd1;
          end else begin
            tail_level <= sel_lvl;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_index <= ovf ? '0 : level_write_pos[sel_lvl];
      key_out    <= key & KEY_MASK;
      tree_level <= ovf ? '0 : sel_lvl;
      last       <= !beyond && is_last;
      overflow   <= ovf;
    end
  end

endmodule

### hdl/static_search_tree_layout.sv
// ----------------------------------------------------------------------------
// static_search_tree_layout
// Assigns each sorted key its slot in a bucketed multi-level search array.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_valid/cfg_ready  item_count
//   in       in   in_valid/in_stall    key
//   out      out  out_valid/out_stall  slot_index, key_out, tree_level, last,
//                                      overflow
//
// After reset and after each item_count write, the level starts are computed
// level by level with a shared reciprocal-multiply divider, with in_stall high
// and cfg_ready low. Afterwards one key transfer per cycle while the held
// result is not stalled by out_stall.
// Each result sits in an output register until taken; a new key is accepted
// in the cycle the held result leaves. rst is synchronous, active high.
// ----------------------------------------------------------------------------
module static_search_tree_layout
  import sstl_pkg::*;
#(
  parameter int BUCKET    = 16,
  parameter int LEVELS    = 4,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SLOT_W-1:0] item_count,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KEY_W-1:0]  key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot_index,
  output logic [KEY_W-1:0]  key_out,
  output logic [LVL_W-1:0]  tree_level,
  output logic              last,
  output logic              overflow
);

  sstl_cmd_t cmd;
  sstl_sts_t sts;

  sstl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sstl_datapath #(
    .BUCKET    (BUCKET),
    .LEVELS    (LEVELS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .item_count (item_count),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot_index (slot_index),
    .key_out    (key_out),
    .tree_level (tree_level),
    .last       (last),
    .overflow   (overflow)
  );

endmodule
